// ===== sv/mst_pkg.sv =====
// ----------------------------------------------------------------------------
// Slide transition package
// Opcodes, sequencer states, register indexes and fixed field widths shared
// by the slide transition compositor.
// ----------------------------------------------------------------------------
package mst_pkg;

	localparam int TIME_W     = 16;
	localparam int ADDR_W     = 10;
	localparam int DATA_W     = 8;
	localparam int OPCODE_W   = 3;
	localparam int OFFS_OUT_W = 7;
	localparam int PAGE_ROWS  = 8;

	localparam logic [TIME_W-1:0] DURATION_RST = 16'd200;
	localparam logic [TIME_W-1:0] TIME_MAX     = 16'hFFFF;

	// configuration register indexes
	localparam logic CFG_DIRECTION = 1'b0;
	localparam logic CFG_DURATION  = 1'b1;

	typedef enum logic [OPCODE_W-1:0] {
		OP_WR_OUT = 3'd0,
		OP_WR_IN  = 3'd1,
		OP_START  = 3'd2,
		OP_TICK   = 3'd3,
		OP_READ   = 3'd4,
		OP_CANCEL = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_TICK,
		ST_DIV,
		ST_ADDR,
		ST_RESULT
	} state_t;

endpackage

// ===== sv/mono_oled_slide_transition.sv =====
// ----------------------------------------------------------------------------
// Monochrome slide transition compositor
// Holds outgoing and incoming page-addressed frames and returns composited
// bytes for a horizontal slide driven by millisecond ticks.
// ----------------------------------------------------------------------------
// Sequence: writes, start, cancel, unused opcodes and an idle tick go from ST_EXEC to ST_RESULT;
// reads pass through ST_ADDR and a tick that ends the slide through ST_TICK; a tick that keeps
// the slide running passes through ST_TICK and then ST_DIV for the shared restoring divider.
// Throughput: one item at a time; the next input transfer can follow in the cycle after the result
// is loaded into the output register. Reset: arst_n clears the sequencer, slide state and
// registers (direction 0, duration 200); frame memories hold garbage until written.
module mono_oled_slide_transition import mst_pkg::*; #(
	parameter int SCREEN_WIDTH  = 128,
	parameter int SCREEN_HEIGHT = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// input item channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [OPCODE_W-1:0]   opcode,
	input  logic [ADDR_W-1:0]     byte_addr,
	input  logic [DATA_W-1:0]     write_data,
	input  logic [TIME_W-1:0]     frame_delta,
	// result channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [DATA_W-1:0]     read_data,
	output logic                  animating,
	output logic [OFFS_OUT_W-1:0] slide_offset,
	// configuration write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic                  cfg_index,
	input  logic [TIME_W-1:0]     cfg_data
);

	// Frame geometry. Only the first 1024 bytes can ever be addressed.
	localparam int FRAME_BYTES = SCREEN_WIDTH * (SCREEN_HEIGHT / PAGE_ROWS);
	localparam int ADDR_SPAN   = 1 << ADDR_W;
	localparam int MEM_DEPTH   = (FRAME_BYTES < ADDR_SPAN) ? FRAME_BYTES : ADDR_SPAN;
	localparam int AW          = $clog2(MEM_DEPTH);
	// column offset and column index both stay below SCREEN_WIDTH
	localparam int OFF_W       = $clog2(SCREEN_WIDTH);
	// dividend of the shared divider: elapsed * SCREEN_WIDTH
	localparam int DVD_W       = TIME_W + $clog2(SCREEN_WIDTH + 1);
	localparam int CNT_W       = $clog2(DVD_W + 1);
	// composited index: base + column + offset stays below 1024 + 2 * width
	localparam int CW          = $clog2(ADDR_SPAN + 2 * SCREEN_WIDTH);
	// page = (address * RCP_M) >> RCP_SH, exact for every 10-bit address
	localparam int RCP_SH      = ADDR_W + $clog2(SCREEN_WIDTH);
	localparam int RCP_M       = ((1 << RCP_SH) + SCREEN_WIDTH - 1) / SCREEN_WIDTH;
	localparam int PRD_W       = RCP_SH + ADDR_W;

	state_t state_q, state_d;

	// live configuration
	logic                  dir_q;
	logic [TIME_W-1:0]     dur_q;
	logic [TIME_W-1:0]     eff_dur;

	// slide state
	logic                  active_q;
	logic [TIME_W-1:0]     elapsed_q;
	logic [OFF_W-1:0]      off_q;

	// captured item
	op_t                   op_q;
	logic [ADDR_W-1:0]     addr_q;
	logic                  addr_ok_q;
	logic [DATA_W-1:0]     data_q;
	logic [TIME_W-1:0]     delta_q;
	logic [ADDR_W-1:0]     page_q;

	// page and column split of the byte address
	logic [PRD_W-1:0]      page_prod;
	logic [ADDR_W-1:0]     page_d;
	logic [ADDR_W-1:0]     page_base;
	logic [ADDR_W-1:0]     col_d;

	// shared divider
	logic [CNT_W-1:0]      cnt_q;
	logic [DVD_W-1:0]      quot_q, quot_d;
	logic [TIME_W-1:0]     rem_q, rem_d;
	logic [TIME_W-1:0]     div_q;
	logic [TIME_W:0]       rem_sh;
	logic                  div_last;

	// tick arithmetic
	logic [TIME_W:0]       elapsed_sum;
	logic [TIME_W-1:0]     elapsed_sat;
	logic                  tick_done;
	logic [DVD_W-1:0]      tick_prod;

	// composited address
	logic [CW-1:0]         base_x, col_x, off_x, w_x, sum_x, idx_d;
	logic                  sel_out_d;
	logic                  sel_out_q, zero_q;

	// frame memories
	logic [DATA_W-1:0]     omem [MEM_DEPTH];
	logic [DATA_W-1:0]     imem [MEM_DEPTH];
	logic [DATA_W-1:0]     omem_q, imem_q;

	// output register
	logic                  out_valid_q;
	logic [DATA_W-1:0]     rd_out_q;
	logic                  anim_out_q;
	logic [OFFS_OUT_W-1:0] offs_out_q;
	logic [31:0]           off_ext;

	logic in_xfer, out_load;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	// the output register takes a new result when it is empty or being drained
	assign out_load  = (state_q == ST_RESULT) && (!out_valid_q || !out_stall);

	assign eff_dur = (dur_q == '0) ? TIME_W'(1) : dur_q;

	// Split the incoming address into page and column by a constant reciprocal.
	assign page_prod = PRD_W'(byte_addr) * PRD_W'(RCP_M);
	assign page_d    = page_prod[RCP_SH +: ADDR_W];
	assign page_base = ADDR_W'(PRD_W'(page_q) * PRD_W'(SCREEN_WIDTH));
	assign col_d     = addr_q - page_base;

	// Saturate elapsed time instead of wrapping.
	assign elapsed_sum = {1'b0, elapsed_q} + {1'b0, delta_q};
	assign elapsed_sat = elapsed_sum[TIME_W] ? TIME_MAX : elapsed_sum[TIME_W-1:0];
	assign tick_done   = (elapsed_q >= eff_dur);
	assign tick_prod   = DVD_W'(elapsed_q) * DVD_W'(SCREEN_WIDTH);

	// One restoring step: shift in the next dividend bit, subtract if it fits.
	assign rem_sh   = {rem_q, quot_q[DVD_W-1]};
	assign div_last = (cnt_q == CNT_W'(1));
	always_comb begin
		if (rem_sh >= {1'b0, div_q}) begin
			rem_d  = TIME_W'(rem_sh - {1'b0, div_q});
			quot_d = {quot_q[DVD_W-2:0], 1'b1};
		end else begin
			rem_d  = rem_sh[TIME_W-1:0];
			quot_d = {quot_q[DVD_W-2:0], 1'b0};
		end
	end

	// Composite addressing. For a read, quotient holds the page and
	// remainder the column of the requested byte.
	assign base_x = CW'(quot_q[ADDR_W-1:0]) * CW'(SCREEN_WIDTH);
	assign col_x  = CW'(rem_q[OFF_W-1:0]);
	assign off_x  = CW'(off_q);
	assign w_x    = CW'(SCREEN_WIDTH);
	assign sum_x  = col_x + off_x;

	always_comb begin
		if (!active_q) begin
			// no slide: show the incoming frame as is
			idx_d     = CW'(addr_q);
			sel_out_d = 1'b0;
		end else if (!dir_q) begin
			// outgoing moves left, incoming fills from the right edge
			if (sum_x < w_x) begin
				idx_d     = base_x + sum_x;
				sel_out_d = 1'b1;
			end else begin
				idx_d     = base_x + sum_x - w_x;
				sel_out_d = 1'b0;
			end
		end else begin
			// outgoing moves right, incoming fills from the left edge
			if (col_x >= off_x) begin
				idx_d     = base_x + col_x - off_x;
				sel_out_d = 1'b1;
			end else begin
				idx_d     = base_x + col_x + w_x - off_x;
				sel_out_d = 1'b0;
			end
		end
	end

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				case (op_q)
					OP_READ: state_d = ST_ADDR;
					OP_TICK: state_d = active_q ? ST_TICK : ST_RESULT;
					default: state_d = ST_RESULT;
				endcase
			end
			ST_TICK: begin
				state_d = tick_done ? ST_RESULT : ST_DIV;
			end
			ST_DIV: begin
				if (div_last) state_d = ST_RESULT;
			end
			ST_ADDR: begin
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (out_load) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control state: configuration, slide state, divider count, output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q       <= 1'b0;
			dur_q       <= DURATION_RST;
			active_q    <= 1'b0;
			elapsed_q   <= '0;
			off_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_DIRECTION) begin
					dir_q <= cfg_data[0];
				end else if (cfg_index == CFG_DURATION) begin
					dur_q <= cfg_data;
				end
			end

			unique case (state_q)
				ST_EXEC: begin
					case (op_q)
						OP_START: begin
							elapsed_q <= '0;
							off_q     <= '0;
							active_q  <= 1'b1;
						end
						OP_CANCEL: begin
							off_q    <= '0;
							active_q <= 1'b0;
						end
						OP_TICK: begin
							if (active_q) elapsed_q <= elapsed_sat;
						end
						default: begin
						end
					endcase
				end
				ST_TICK: begin
					if (tick_done) begin
						active_q <= 1'b0;
						off_q    <= '0;
					end else begin
						cnt_q <= CNT_W'(DVD_W);
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q - CNT_W'(1);
					// quotient of a tick divide is below the width
					if (div_last && op_q == OP_TICK) off_q <= quot_d[OFF_W-1:0];
				end
				default: begin
				end
			endcase

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload: captured item, divider operands, read select, output fields.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_q      <= op_t'(opcode);
			addr_q    <= byte_addr;
			addr_ok_q <= (32'(byte_addr) < 32'(FRAME_BYTES));
			data_q    <= write_data;
			delta_q   <= frame_delta;
			page_q    <= page_d;
		end

		if (state_q == ST_EXEC && op_q == OP_READ) begin
			// hold page and column for the composite address
			quot_q <= DVD_W'(page_q);
			rem_q  <= TIME_W'(col_d);
		end else if (state_q == ST_TICK) begin
			// offset = elapsed * width / duration
			quot_q <= tick_prod;
			rem_q  <= '0;
			div_q  <= eff_dur;
		end else if (state_q == ST_DIV) begin
			quot_q <= quot_d;
			rem_q  <= rem_d;
		end

		if (state_q == ST_ADDR) begin
			sel_out_q <= sel_out_d;
			zero_q    <= !addr_ok_q;
		end

		if (out_load) begin
			if (op_q == OP_READ && !zero_q) begin
				rd_out_q <= sel_out_q ? omem_q : imem_q;
			end else begin
				rd_out_q <= '0;
			end
			anim_out_q <= active_q;
			offs_out_q <= off_ext[OFFS_OUT_W-1:0];
		end
	end

	assign off_ext = 32'(off_q);

	// Outgoing frame memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (state_q == ST_EXEC && op_q == OP_WR_OUT && addr_ok_q) begin
			omem[addr_q[AW-1:0]] <= data_q;
		end
		if (state_q == ST_ADDR) begin
			omem_q <= omem[idx_d[AW-1:0]];
		end
	end

	// Incoming frame memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (state_q == ST_EXEC && op_q == OP_WR_IN && addr_ok_q) begin
			imem[addr_q[AW-1:0]] <= data_q;
		end
		if (state_q == ST_ADDR) begin
			imem_q <= imem[idx_d[AW-1:0]];
		end
	end

	assign out_valid    = out_valid_q;
	assign read_data    = rd_out_q;
	assign animating    = anim_out_q;
	assign slide_offset = offs_out_q;

endmodule
